// ===== rtl/core/b64d_pkg.sv =====
// Shared types and constants for the streaming base64 decoder.
// Used by b64d_lookup, b64d_unpack and base64_stream_decoder; no dependencies.
`default_nettype none

package b64d_pkg;

  // Class of one text character after the alphabet lookup.
  typedef enum logic [1:0] {
    SYM_DATA,
    SYM_SKIP,
    SYM_PAD,
    SYM_BAD
  } sym_kind_t;

  typedef struct packed {
    sym_kind_t   kind;
    logic [5:0]  value;
  } sym_t;

  // Stream status as reported on the result channel.
  typedef enum logic [1:0] {
    ST_DECODING = 2'd0,
    ST_PADDED   = 2'd1,
    ST_ERROR    = 2'd2
  } status_t;

  // Leftover bits are always a whole number of bit pairs (0, 2, 4 or 6 bits).
  localparam int unsigned PairCountWidth = 2;

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChEquals = 8'h3D;

  localparam logic [5:0] OffsetLower = 6'd26;
  localparam logic [5:0] OffsetDigit = 6'd52;
  localparam logic [5:0] ValPlus     = 6'd62;
  localparam logic [5:0] ValSlash    = 6'd63;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    status_t    status;
    logic       text_done;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/b64d_lookup.sv =====
// Alphabet lookup: classifies one character and gives its six-bit value.
// Depends on b64d_pkg.
`default_nettype none

module b64d_lookup (
  input  wire logic [7:0]   char_code,
  output b64d_pkg::sym_t    sym
);
  import b64d_pkg::*;

  logic [7:0] rel_upper;
  logic [7:0] rel_lower;
  logic [7:0] rel_digit;

  assign rel_upper = char_code - ChUpperA;
  assign rel_lower = char_code - ChLowerA;
  assign rel_digit = char_code - ChDigit0;

  always_comb begin
    sym.kind  = SYM_BAD;
    sym.value = '0;
    if (char_code >= ChUpperA && char_code <= ChUpperZ) begin
      sym.kind  = SYM_DATA;
      sym.value = rel_upper[5:0];
    end else if (char_code >= ChLowerA && char_code <= ChLowerZ) begin
      sym.kind  = SYM_DATA;
      sym.value = rel_lower[5:0] + OffsetLower;
    end else if (char_code >= ChDigit0 && char_code <= ChDigit9) begin
      sym.kind  = SYM_DATA;
      sym.value = rel_digit[5:0] + OffsetDigit;
    end else if (char_code == ChPlus || char_code == ChMinus) begin
      sym.kind  = SYM_DATA;
      sym.value = ValPlus;
    end else if (char_code == ChSlash || char_code == ChUnder) begin
      sym.kind  = SYM_DATA;
      sym.value = ValSlash;
    end else if (char_code == ChSpace || char_code == ChTab ||
                 char_code == ChCr || char_code == ChLf) begin
      sym.kind  = SYM_SKIP;
    end else if (char_code == ChEquals) begin
      sym.kind  = SYM_PAD;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b64d_unpack.sv =====
// Bit gathering: holds the leftover bits, pair count and stream status, and
// forms the result for one classified character. Depends on b64d_pkg.
`default_nettype none

module b64d_unpack (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire b64d_pkg::sym_t  sym,
  input  wire logic            start_of_text,
  input  wire logic            end_of_text,
  output b64d_pkg::result_t    result
);
  import b64d_pkg::*;

  logic [5:0]                leftover_bits;
  logic [5:0]                leftover_bits_next;
  logic [PairCountWidth-1:0] pair_count;
  logic [PairCountWidth-1:0] pair_count_next;
  status_t                   stream_status;
  status_t                   stream_status_next;

  // Effective state for this character once start of text has been applied.
  logic [5:0]                cur_bits;
  logic [PairCountWidth-1:0] cur_pairs;
  status_t                   cur_status;
  logic [5:0]                gather_bits;
  logic [PairCountWidth-1:0] gather_pairs;
  logic [7:0]                gather_byte;
  logic                      gather_valid;

  assign cur_bits   = start_of_text ? '0 : leftover_bits;
  assign cur_pairs  = start_of_text ? '0 : pair_count;
  assign cur_status = start_of_text ? ST_DECODING : stream_status;

  // Six new bits join 0, 2, 4 or 6 held bits; a byte leaves once eight gather.
  always_comb begin
    gather_byte  = '0;
    gather_valid = 1'b0;
    gather_bits  = '0;
    gather_pairs = '0;
    case (cur_pairs)
      2'd0: begin
        gather_bits  = sym.value;
        gather_pairs = 2'd3;
      end
      2'd1: begin
        gather_byte  = {cur_bits[1:0], sym.value};
        gather_valid = 1'b1;
      end
      2'd2: begin
        gather_byte  = {cur_bits[3:0], sym.value[5:2]};
        gather_valid = 1'b1;
        gather_bits  = {4'd0, sym.value[1:0]};
        gather_pairs = 2'd1;
      end
      default: begin
        gather_byte  = {cur_bits[5:0], sym.value[5:4]};
        gather_valid = 1'b1;
        gather_bits  = {2'd0, sym.value[3:0]};
        gather_pairs = 2'd2;
      end
    endcase
  end

  always_comb begin
    result.data_byte   = '0;
    result.byte_valid  = 1'b0;
    result.status      = cur_status;
    result.text_done   = end_of_text;
    leftover_bits_next = cur_bits;
    pair_count_next    = cur_pairs;
    if (cur_status == ST_DECODING) begin
      unique case (sym.kind)
        SYM_PAD: result.status = ST_PADDED;
        SYM_BAD: result.status = ST_ERROR;
        SYM_SKIP: ;
        SYM_DATA: begin
          result.data_byte   = gather_byte;
          result.byte_valid  = gather_valid;
          leftover_bits_next = gather_bits;
          pair_count_next    = gather_pairs;
        end
        default: ;
      endcase
    end
    stream_status_next = result.status;
    // The final character of a text leaves the decoder ready for a new one.
    if (end_of_text) begin
      leftover_bits_next = '0;
      pair_count_next    = '0;
      stream_status_next = ST_DECODING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits <= '0;
      pair_count    <= '0;
      stream_status <= ST_DECODING;
    end else if (step) begin
      leftover_bits <= leftover_bits_next;
      pair_count    <= pair_count_next;
      stream_status <= stream_status_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/base64_stream_decoder.sv =====
// Top level of the streaming base64 decoder: input register, lookup and bit
// gathering, result register. Depends on b64d_pkg, b64d_lookup, b64d_unpack.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+---------------------------------------------
//   source  | src_valid/src_stall | char_code, start_of_text, end_of_text
//   result  | res_valid/res_stall | data_byte, byte_valid, status, text_done
//
// One character is taken per clock while src_stall is low; it is held in the input
// register, and its result is loaded from there into the result register.
// The leftover-bit register is updated as each result is loaded.
// rst is synchronous and clears both stage valids and the decoder state.
// A stalled result holds the pipe; src_stall rises only while both stages
// are full and res_stall is high.
`default_nettype none

module base64_stream_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       src_valid,
  output logic            src_stall,
  input  wire logic [7:0] char_code,
  input  wire logic       start_of_text,
  input  wire logic       end_of_text,
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic [7:0]      data_byte,
  output logic            byte_valid,
  output logic [1:0]      status,
  output logic            text_done
);
  import b64d_pkg::*;

  logic       in_full;
  logic [7:0] in_char;
  logic       in_sot;
  logic       in_eot;
  logic       res_move;
  logic       in_move;
  sym_t       sym;
  result_t    result_next;
  result_t    result;

  assign res_move  = !res_valid || !res_stall;
  assign src_stall = in_full && !res_move;
  assign in_move   = src_valid && !src_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_move) begin
      in_full <= 1'b1;
    end else if (res_move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move) begin
      in_char <= char_code;
      in_sot  <= start_of_text;
      in_eot  <= end_of_text;
    end
  end

  b64d_lookup u_lookup (
    .char_code (in_char),
    .sym       (sym)
  );

  b64d_unpack u_unpack (
    .clk           (clk),
    .rst           (rst),
    .step          (in_full && res_move),
    .sym           (sym),
    .start_of_text (in_sot),
    .end_of_text   (in_eot),
    .result        (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_move) begin
      res_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (res_move && in_full) begin
      result <= result_next;
    end
  end

  assign data_byte  = result.data_byte;
  assign byte_valid = result.byte_valid;
  assign status     = result.status;
  assign text_done  = result.text_done;

endmodule

`default_nettype wire
